@@ rtl/ccsx_pkg.sv @@
// shared types, constants and round functions for the chacha20 stream xor block
package ccsx_pkg;

  localparam int unsigned DoubleRoundsDef = 10;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned WordW           = 32;
  localparam int unsigned NumWords        = 16;
  localparam int unsigned PosW            = 7;

  localparam logic [WordW-1:0] Sigma0 = 32'h6170_7865;
  localparam logic [WordW-1:0] Sigma1 = 32'h3320_646e;
  localparam logic [WordW-1:0] Sigma2 = 32'h7962_2d32;
  localparam logic [WordW-1:0] Sigma3 = 32'h6b20_6574;

  typedef logic [NumWords-1:0][WordW-1:0] blk_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_NONCEL = 3'd4,
    REG_NONCEH = 3'd5,
    REG_START  = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } ccsx_state_e;

  typedef struct packed {
    logic take;
    logic start_block;
    logic do_round;
    logic finish;
  } ccsx_cmd_t;

  typedef struct packed {
    logic need_block;
    logic out_free;
    logic round_last;
  } ccsx_status_t;

  function automatic logic [3:0][WordW-1:0] qround(
    input logic [WordW-1:0] a_in,
    input logic [WordW-1:0] b_in,
    input logic [WordW-1:0] c_in,
    input logic [WordW-1:0] d_in
  );
    logic [WordW-1:0] a, b, c, d, t;
    logic [3:0][WordW-1:0] res;
    a = a_in + b_in;
    t = d_in ^ a;
    d = {t[15:0], t[31:16]};
    c = c_in + d;
    t = b_in ^ c;
    b = {t[19:0], t[31:20]};
    a = a + b;
    t = d ^ a;
    d = {t[23:0], t[31:24]};
    c = c + d;
    t = b ^ c;
    b = {t[24:0], t[31:25]};
    res = {d, c, b, a};
    return res;
  endfunction

  // one column round or one diagonal round, four quarter rounds side by side
  function automatic blk_t round_f(input blk_t w, input logic diag);
    blk_t res;
    logic [3:0][WordW-1:0] q;
    int unsigned ib, ic, id;
    res = w;
    for (int unsigned i = 0; i < 4; i++) begin
      if (diag) begin
        ib = 4 + ((i + 1) % 4);
        ic = 8 + ((i + 2) % 4);
        id = 12 + ((i + 3) % 4);
      end else begin
        ib = 4 + i;
        ic = 8 + i;
        id = 12 + i;
      end
      q = qround(w[i], w[ib], w[ic], w[id]);
      res[i]  = q[0];
      res[ib] = q[1];
      res[ic] = q[2];
      res[id] = q[3];
    end
    return res;
  endfunction

endpackage

@@ rtl/ccsx_ctrl.sv @@
// controller state machine: accepts beats and sequences keystream block generation
module ccsx_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ccsx_pkg::ccsx_status_t status_i,
  output ccsx_pkg::ccsx_cmd_t    cmd_o
);

  ccsx_pkg::ccsx_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccsx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ccsx_pkg::ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.take = 1'b1;
          if (status_i.need_block) begin
            cmd_o.start_block = 1'b1;
            state_d           = ccsx_pkg::ST_ROUND;
          end
        end
      end
      ccsx_pkg::ST_ROUND: begin
        cmd_o.do_round = 1'b1;
        if (status_i.round_last) begin
          state_d = ccsx_pkg::ST_FINAL;
        end
      end
      ccsx_pkg::ST_FINAL: begin
        cmd_o.finish = 1'b1;
        state_d      = ccsx_pkg::ST_IDLE;
      end
      default: begin
        state_d = ccsx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ccsx_datapath.sv @@
// datapath: config registers, round state, keystream buffer, counter and output register
module ccsx_datapath #(
  parameter int unsigned DOUBLE_ROUNDS = ccsx_pkg::DoubleRoundsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ccsx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ccsx_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [7:0]                    cipher_byte_i,
  input  logic                          restart_i,
  input  logic                          chunk_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    plain_byte_o,
  output logic                          chunk_last_o,
  input  ccsx_pkg::ccsx_cmd_t           cmd_i,
  output ccsx_pkg::ccsx_status_t        status_o
);

  localparam int unsigned NumRounds = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RndCntW   = $clog2(NumRounds);
  localparam logic [RndCntW-1:0] RndLast = RndCntW'(NumRounds - 1);

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0] nonce_hi_q, start_q;
  logic [31:0] counter_q;
  logic [ccsx_pkg::PosW-1:0] pos_q;
  logic [RndCntW-1:0] rnd_q;
  ccsx_pkg::blk_t work_q, ks_q, init_w, init_load, ks_new;
  logic [7:0] byte_q, plain_q;
  logic last_q, chunk_q, out_valid_q;
  logic [31:0] ks_word;
  logic [7:0] ks_byte;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
      start_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ccsx_pkg::REG_KEY0:   key0_q     <= cfg_data_i;
        ccsx_pkg::REG_KEY1:   key1_q     <= cfg_data_i;
        ccsx_pkg::REG_KEY2:   key2_q     <= cfg_data_i;
        ccsx_pkg::REG_KEY3:   key3_q     <= cfg_data_i;
        ccsx_pkg::REG_NONCEL: nonce_lo_q <= cfg_data_i;
        ccsx_pkg::REG_NONCEH: nonce_hi_q <= cfg_data_i[31:0];
        ccsx_pkg::REG_START:  start_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // initial block words
  always_comb begin
    init_w[0]  = ccsx_pkg::Sigma0;
    init_w[1]  = ccsx_pkg::Sigma1;
    init_w[2]  = ccsx_pkg::Sigma2;
    init_w[3]  = ccsx_pkg::Sigma3;
    init_w[4]  = key0_q[31:0];
    init_w[5]  = key0_q[63:32];
    init_w[6]  = key1_q[31:0];
    init_w[7]  = key1_q[63:32];
    init_w[8]  = key2_q[31:0];
    init_w[9]  = key2_q[63:32];
    init_w[10] = key3_q[31:0];
    init_w[11] = key3_q[63:32];
    init_w[12] = counter_q;
    init_w[13] = nonce_lo_q[31:0];
    init_w[14] = nonce_lo_q[63:32];
    init_w[15] = nonce_hi_q;
    init_load     = init_w;
    init_load[12] = restart_i ? start_q : counter_q;
    for (int unsigned i = 0; i < ccsx_pkg::NumWords; i++) begin
      ks_new[i] = work_q[i] + init_w[i];
    end
  end

  assign ks_word = ks_q[pos_q[5:2]];
  assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

  // control state: counter, byte position, round count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      pos_q       <= ccsx_pkg::PosW'(64);
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((cmd_i.take && !cmd_i.start_block) || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.take && cmd_i.start_block) begin
        counter_q <= init_load[12];
        rnd_q     <= '0;
      end else if (cmd_i.take) begin
        pos_q <= pos_q + ccsx_pkg::PosW'(1);
      end
      if (cmd_i.do_round) begin
        rnd_q <= rnd_q + RndCntW'(1);
      end
      if (cmd_i.finish) begin
        counter_q <= counter_q + 32'd1;
        pos_q     <= ccsx_pkg::PosW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && cmd_i.start_block) begin
      work_q  <= init_load;
      byte_q  <= cipher_byte_i;
      last_q  <= chunk_end_i;
    end else if (cmd_i.take) begin
      plain_q <= cipher_byte_i ^ ks_byte;
      chunk_q <= chunk_end_i;
    end
    if (cmd_i.do_round) begin
      work_q <= ccsx_pkg::round_f(work_q, rnd_q[0]);
    end
    if (cmd_i.finish) begin
      ks_q    <= ks_new;
      plain_q <= byte_q ^ ks_new[0][7:0];
      chunk_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = plain_q;
  assign chunk_last_o = chunk_q;

  assign status_o.need_block = restart_i || pos_q[6];
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.round_last = (rnd_q == RndLast);

endmodule

@@ rtl/chacha20_stream_xor_top.sv @@
// top level of the chacha20 stream xor block
//
// channel   direction  signals                                  width
// cfg       in         cfg_valid_i/cfg_ready_o, index, data      3, 64
// in        in         in_valid_i/in_ready_o, byte, restart, end 8, 1, 1
// out       out        out_valid_o/out_ready_i, byte, last       8, 1
//
// a beat that uses a buffered keystream byte is xored with it and registered; a
// new beat can be taken every cycle while the output beat is drained
// a beat that needs a new keystream block (every 64th, or restart) runs
// 2 * DOUBLE_ROUNDS rounds, one round of the quarter-round unit per cycle
// reset clears the counter and marks the keystream buffer empty
// a stalled output holds the next input beat off; config writes are always taken
module chacha20_stream_xor_top #(
  parameter int unsigned DOUBLE_ROUNDS = ccsx_pkg::DoubleRoundsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ccsx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ccsx_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    cipher_byte_i,
  input  logic                          restart_i,
  input  logic                          chunk_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    plain_byte_o,
  output logic                          chunk_last_o
);

  ccsx_pkg::ccsx_cmd_t    cmd;
  ccsx_pkg::ccsx_status_t status;

  assign cfg_ready_o = 1'b1;

  ccsx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ccsx_datapath #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cipher_byte_i (cipher_byte_i),
    .restart_i     (restart_i),
    .chunk_end_i   (chunk_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .plain_byte_o  (plain_byte_o),
    .chunk_last_o  (chunk_last_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

@@ tb/tb_chacha20_stream_xor_top.sv @@
// testbench for the chacha20 stream xor block: keystream predictor, beat driver and checker
module tb_chacha20_stream_xor_top;

  localparam int unsigned DoubleRounds  = ccsx_pkg::DoubleRoundsDef;
  localparam int unsigned LatencyCycles = 2 * DoubleRounds + 6;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned PhaseBeats    = 70;
  localparam int unsigned MaxPrints     = 100;
  localparam logic [ccsx_pkg::CfgIdxW-1:0] RegNone = 3'd7;

  typedef logic [ccsx_pkg::NumWords-1:0][ccsx_pkg::WordW-1:0] words_t;

  typedef struct packed {
    logic [7:0] cbyte;
    logic       restart;
    logic       chunk_end;
  } cipher_beat_t;

  typedef struct packed {
    logic [7:0] plain;
    logic       chunk_last;
  } plain_beat_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [ccsx_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [ccsx_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    cipher_byte_i = '0;
  logic                          restart_i     = 1'b0;
  logic                          chunk_end_i   = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [7:0]                    plain_byte_o;
  logic                          chunk_last_o;

  chacha20_stream_xor_top #(
    .DOUBLE_ROUNDS(DoubleRounds)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cipher_byte_i(cipher_byte_i),
    .restart_i    (restart_i),
    .chunk_end_i  (chunk_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .plain_byte_o (plain_byte_o),
    .chunk_last_o (chunk_last_o)
  );

  // predictor state
  logic [63:0]  cfg_key [4];
  logic [63:0]  cfg_nonce_lo;
  logic [31:0]  cfg_nonce_hi;
  logic [31:0]  cfg_ctr_start;
  logic [31:0]  blk_ctr;
  int unsigned  ks_pos;
  words_t       ks_buf;

  cipher_beat_t cipher_q[$];
  plain_beat_t  plain_q[$];
  cipher_beat_t drv_beat;
  plain_beat_t  mon_beat;

  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct     = 0;
  int unsigned  err_cnt       = 0;
  bit           hold_go       = 1'b0;
  logic         hold_rx       = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic words_t quarter_mix(input words_t w, input int unsigned a,
                                         input int unsigned b, input int unsigned c,
                                         input int unsigned d);
    w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic words_t chacha_block(input logic [31:0] ctr_val);
    words_t init_w;
    words_t mix_w;
    init_w[0] = ccsx_pkg::Sigma0;
    init_w[1] = ccsx_pkg::Sigma1;
    init_w[2] = ccsx_pkg::Sigma2;
    init_w[3] = ccsx_pkg::Sigma3;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2 * k] = cfg_key[k][31:0];
      init_w[5 + 2 * k] = cfg_key[k][63:32];
    end
    init_w[12] = ctr_val;
    init_w[13] = cfg_nonce_lo[31:0];
    init_w[14] = cfg_nonce_lo[63:32];
    init_w[15] = cfg_nonce_hi;
    mix_w = init_w;
    for (int r = 0; r < DoubleRounds; r++) begin
      mix_w = quarter_mix(mix_w, 0, 4, 8, 12);
      mix_w = quarter_mix(mix_w, 1, 5, 9, 13);
      mix_w = quarter_mix(mix_w, 2, 6, 10, 14);
      mix_w = quarter_mix(mix_w, 3, 7, 11, 15);
      mix_w = quarter_mix(mix_w, 0, 5, 10, 15);
      mix_w = quarter_mix(mix_w, 1, 6, 11, 12);
      mix_w = quarter_mix(mix_w, 2, 7, 8, 13);
      mix_w = quarter_mix(mix_w, 3, 4, 9, 14);
    end
    for (int i = 0; i < ccsx_pkg::NumWords; i++) mix_w[i] = mix_w[i] + init_w[i];
    return mix_w;
  endfunction

  task automatic xor_keystream(input cipher_beat_t b, output plain_beat_t r);
    logic [31:0] w;
    if (b.restart) begin
      blk_ctr = cfg_ctr_start;
      ks_pos  = 64;
    end
    if (ks_pos >= 64) begin
      ks_buf  = chacha_block(blk_ctr);
      blk_ctr = blk_ctr + 32'd1;
      ks_pos  = 0;
    end
    w            = ks_buf[ks_pos / 4];
    r.plain      = b.cbyte ^ w[8 * (ks_pos % 4) +: 8];
    r.chunk_last = b.chunk_end;
    ks_pos++;
  endtask

  task automatic queue_beat(input logic [7:0] cb, input logic rs, input logic ce);
    cipher_beat_t b;
    plain_beat_t  r;
    b.cbyte     = cb;
    b.restart   = rs;
    b.chunk_end = ce;
    xor_keystream(b, r);
    cipher_q.push_back(b);
    plain_q.push_back(r);
  endtask

  task automatic queue_random(input int unsigned n, input int unsigned restart_pct);
    for (int unsigned i = 0; i < n; i++) begin
      queue_beat(8'($urandom_range(255)), $urandom_range(99) < restart_pct,
                 $urandom_range(7) == 0);
    end
  endtask

  task automatic write_reg(input logic [ccsx_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ccsx_pkg::REG_KEY0:   cfg_key[0]    = val;
      ccsx_pkg::REG_KEY1:   cfg_key[1]    = val;
      ccsx_pkg::REG_KEY2:   cfg_key[2]    = val;
      ccsx_pkg::REG_KEY3:   cfg_key[3]    = val;
      ccsx_pkg::REG_NONCEL: cfg_nonce_lo  = val;
      ccsx_pkg::REG_NONCEH: cfg_nonce_hi  = val[31:0];
      ccsx_pkg::REG_START:  cfg_ctr_start = val[31:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (cipher_q.size() != 0 || in_valid_i || plain_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < MaxPrints)
      $display("mismatch on %s: got %02h, want %02h", field, got, want);
    err_cnt++;
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (cipher_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_beat = cipher_q.pop_front();
        in_valid_i    <= 1'b1;
        cipher_byte_i <= drv_beat.cbyte;
        restart_i     <= drv_beat.restart;
        chunk_end_i   <= drv_beat.chunk_end;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (plain_q.size() == 0) begin
        report_mismatch("unexpected beat", plain_byte_o, 8'h00);
      end else begin
        mon_beat = plain_q.pop_front();
        if (plain_byte_o !== mon_beat.plain)
          report_mismatch("plain_byte", plain_byte_o, mon_beat.plain);
        if (chunk_last_o !== mon_beat.chunk_last)
          report_mismatch("chunk_last", {7'd0, chunk_last_o}, {7'd0, mon_beat.chunk_last});
      end
    end
  end

  initial begin
    logic [63:0] fill;
    for (int k = 0; k < 4; k++) cfg_key[k] = '0;
    cfg_nonce_lo  = '0;
    cfg_nonce_hi  = '0;
    cfg_ctr_start = '0;
    blk_ctr       = '0;
    ks_pos        = 64;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key and counter
    queue_beat(8'h00, 1'b0, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b1);
    wait_idle();

    write_reg(ccsx_pkg::REG_KEY0,   64'h0706_0504_0302_0100);
    write_reg(ccsx_pkg::REG_KEY1,   64'h0f0e_0d0c_0b0a_0908);
    write_reg(ccsx_pkg::REG_KEY2,   64'h1716_1514_1312_1110);
    write_reg(ccsx_pkg::REG_KEY3,   64'h1f1e_1d1c_1b1a_1918);
    write_reg(ccsx_pkg::REG_NONCEL, 64'h4a00_0000_0900_0000);
    write_reg(ccsx_pkg::REG_NONCEH, 64'hFFFF_FFFF_0000_0000);
    write_reg(ccsx_pkg::REG_START,  64'h0000_0000_0000_0001);
    write_reg(RegNone,              64'hFFFF_FFFF_FFFF_FFFF);

    // old keystream still in use until the restart
    queue_beat(8'h5A, 1'b0, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b0);
    queue_beat(8'h80, 1'b0, 1'b1);
    queue_beat(8'h01, 1'b0, 1'b0);
    queue_beat(8'h7F, 1'b1, 1'b1);
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'hC3, 1'b0, 1'b1);
    wait_idle();

    write_reg(ccsx_pkg::REG_START, 64'h0000_0000_FFFF_FFFF);
    queue_beat(8'hAA, 1'b1, 1'b0);
    queue_beat(8'h55, 1'b0, 1'b1);
    queue_beat(8'h0F, 1'b0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      if (ph == 0 || ph == 1) begin
        fill = (ph == 0) ? '0 : '1;
        write_reg(ccsx_pkg::REG_KEY0, fill);
        write_reg(ccsx_pkg::REG_KEY1, fill);
        write_reg(ccsx_pkg::REG_KEY2, fill);
        write_reg(ccsx_pkg::REG_KEY3, fill);
        write_reg(ccsx_pkg::REG_NONCEL, fill);
        write_reg(ccsx_pkg::REG_NONCEH, fill);
        write_reg(ccsx_pkg::REG_START, fill);
      end else begin
        write_reg(ccsx_pkg::CfgIdxW'(ccsx_pkg::REG_KEY0 + $urandom_range(3)),
                  {$urandom, $urandom});
        if ($urandom_range(1)) write_reg(ccsx_pkg::REG_NONCEL, {$urandom, $urandom});
        if ($urandom_range(1)) write_reg(ccsx_pkg::REG_NONCEH, {$urandom, $urandom});
        if ($urandom_range(3) == 0) write_reg(RegNone, {$urandom, $urandom});
        case ($urandom_range(3))
          0: fill = {$urandom, 32'hFFFF_FFFE};
          1: fill = {$urandom, 32'h0000_0000};
          default: fill = {$urandom, $urandom};
        endcase
        if (ph == 2) fill = {$urandom, 32'hFFFF_FFFF};
        write_reg(ccsx_pkg::REG_START, fill);
      end
      // counter wrap phase runs well past one block without restart
      queue_beat(8'($urandom_range(255)), ph == 2 || $urandom_range(1),
                 1'($urandom_range(1)));
      queue_random(PhaseBeats - 1, (ph == 2) ? 0 : 3);
    end

    wait_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(ccsx_pkg::CfgIdxW'(ccsx_pkg::REG_KEY2 + $urandom_range(1)),
              {$urandom, $urandom});
    queue_random(130, 2);
    hold_go = 1'b1;

    wait_idle();
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ccsx_pkg.sv
rtl/ccsx_ctrl.sv
rtl/ccsx_datapath.sv
rtl/chacha20_stream_xor_top.sv
tb/tb_chacha20_stream_xor_top.sv
